// ===== src/mdr_pkg.sv =====
// Package for the modular dot-product core with delayed reduction.
// Holds widths, register indexes, sequencer states and control structs.
// No dependencies; compile first.
package mdr_pkg;

   // Default parameter values and fixed field widths.
   localparam int ELEM_WIDTH_DEF  = 16;
   localparam int ACC_WIDTH_DEF   = 32;
   localparam int MOD_WIDTH       = 16;
   localparam int CHUNK_WIDTH     = 16;
   localparam int OFFSET_WIDTH    = 32;
   localparam int RES_WIDTH       = 16;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODULUS       = 2'd0,
      CSR_CHUNK_LENGTH  = 2'd1,
      CSR_REDUCE_OFFSET = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_SUB,
      ST_DIV,
      ST_FIN
   } seq_state_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic req_fire;
      logic last;
      logic chunk_hit;
      logic mod_zero;
      logic step_last;
      logic out_free;
   } status_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic ready;
      logic load;
      logic mul;
      logic acc;
      logic sub;
      logic div;
      logic fin;
   } ctrl_type;

endpackage

// ===== src/mdr_if.sv =====
// Request and response channel interfaces of the modular dot-product core.
// Depends on mdr_pkg for the field widths.
interface mdr_req_if
   import mdr_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [ELEM_WIDTH-1:0] a_elem;
   logic [ELEM_WIDTH-1:0] b_elem;
   logic                  last_term;

   modport source (output valid, a_elem, b_elem, last_term, input ready);
   modport sink   (input valid, a_elem, b_elem, last_term, output ready);
endinterface

interface mdr_rsp_if
   import mdr_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [RES_WIDTH-1:0] residue;

   modport source (output valid, residue, input ready);
   modport sink   (input valid, residue, output ready);
endinterface

// ===== src/mdr_cmpsub.sv =====
// Shared compare-and-subtract unit: one wide subtract that yields a >= b.
// Used for the offset reduction and each restoring remainder step.
// No package dependency.
module mdr_cmpsub #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   output logic             ge,
   output logic [WIDTH-1:0] diff
);
   logic [WIDTH:0] full;

   // The borrow out of the extended subtract is low exactly when opa >= opb.
   assign full = {1'b0, opa} - {1'b0, opb};
   assign ge   = ~full[WIDTH];
   assign diff = full[WIDTH-1:0];
endmodule

// ===== src/mdr_seq.sv =====
// Sequencer of the modular dot-product core.
// Steps one request through multiply, accumulate, reduction and remainder.
// Depends on mdr_pkg.
module mdr_seq
   import mdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);
   seq_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and controls.
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.ready = 1'b1;
            if (status.req_fire) begin
               ctrl.load = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctrl.acc = 1'b1;
            if (status.last) begin
               state_in = status.mod_zero ? ST_FIN : ST_DIV;
            end else begin
               state_in = status.chunk_hit ? ST_SUB : ST_IDLE;
            end
         end
         ST_SUB: begin
            ctrl.sub = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            ctrl.div = 1'b1;
            if (status.step_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               ctrl.fin = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== src/modular_dot_product_delayed_reduction_core.sv =====
// Top level of the modular dot-product core with delayed reduction.
// Depends on mdr_pkg, mdr_if (interfaces), mdr_cmpsub and mdr_seq.
//
//   Channel | Ports              | Direction | Moves
//   req     | valid ready fields | in        | a_elem, b_elem, last_term
//   rsp     | valid ready fields | out       | residue
//   csr     | csr_we/index/wdata | in        | modulus, chunk_length, reduce_offset
//
// A request without last_term passes through load, multiply and accumulate,
// plus one extra pass through the shared compare-subtract unit for the offset
// when it closes a chunk. A last request then forms the remainder one bit per
// cycle by the same compare-subtract unit; with modulus zero those steps are skipped.
// Reset is synchronous; it clears the sum, the chunk count and the response valid, and loads configuration defaults.
// A stalled response sits in the output register; the next request is
// accepted meanwhile, and only a second result waits for it to drain.
module modular_dot_product_delayed_reduction_core
   import mdr_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   mdr_req_if.sink                    req,
   mdr_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);
   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
   localparam int SUM_WIDTH  = (PROD_WIDTH > ACC_WIDTH) ? PROD_WIDTH : ACC_WIDTH;
   localparam int CMP_WIDTH  = (ACC_WIDTH > OFFSET_WIDTH) ? ACC_WIDTH : OFFSET_WIDTH;
   localparam int IDX_WIDTH  = $clog2(ACC_WIDTH);

   // Configuration registers.
   logic [MOD_WIDTH-1:0]    modulus_ff;
   logic [CHUNK_WIDTH-1:0]  chunk_length_ff;
   logic [OFFSET_WIDTH-1:0] reduce_offset_ff;

   // Operands, product and running state.
   logic [ELEM_WIDTH-1:0]  a_ff, b_ff;
   logic                   last_ff;
   logic [PROD_WIDTH-1:0]  prod_ff;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [CHUNK_WIDTH-1:0] chunk_count_ff, chunk_count_in;
   logic [MOD_WIDTH-1:0]   rem_ff, rem_in;
   logic [IDX_WIDTH-1:0]   bit_idx_ff, bit_idx_in;
   logic                   rsp_valid_ff;
   logic [RES_WIDTH-1:0]   residue_ff;

   logic [SUM_WIDTH-1:0]   sum;
   logic [CHUNK_WIDTH-1:0] chunk_next;
   logic [MOD_WIDTH:0]     rem_shift;
   logic [CMP_WIDTH-1:0]   opa, opb, diff;
   logic                   ge;
   status_type             status;
   ctrl_type               ctrl;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff       <= MOD_WIDTH'(32003);
         chunk_length_ff  <= CHUNK_WIDTH'(1);
         reduce_offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:       modulus_ff       <= csr_wdata[MOD_WIDTH-1:0];
            CSR_CHUNK_LENGTH:  chunk_length_ff  <= csr_wdata[CHUNK_WIDTH-1:0];
            CSR_REDUCE_OFFSET: reduce_offset_ff <= csr_wdata[OFFSET_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   assign chunk_next = chunk_count_ff + CHUNK_WIDTH'(1);
   assign rem_shift  = {rem_ff, acc_ff[bit_idx_ff]};

   assign status.req_fire  = req.valid && ctrl.ready;
   assign status.last      = last_ff;
   assign status.chunk_hit = (chunk_next == chunk_length_ff);
   assign status.mod_zero  = (modulus_ff == '0);
   assign status.step_last = (bit_idx_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

   mdr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Shared unit: offset check in the reduction step, else one remainder step.
   always_comb begin
      if (ctrl.sub) begin
         opa = CMP_WIDTH'(acc_ff);
         opb = CMP_WIDTH'(reduce_offset_ff);
      end else begin
         opa = CMP_WIDTH'(rem_shift);
         opb = CMP_WIDTH'(modulus_ff);
      end
   end

   mdr_cmpsub #(
      .WIDTH (CMP_WIDTH)
   ) u_cmpsub (
      .opa  (opa),
      .opb  (opb),
      .ge   (ge),
      .diff (diff)
   );

   // Operand capture and product register.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff    <= req.a_elem;
         b_ff    <= req.b_elem;
         last_ff <= req.last_term;
      end
      if (ctrl.mul) begin
         prod_ff <= a_ff * b_ff;
      end
   end

   // Accumulator, chunk counter and remainder next values.
   assign sum = SUM_WIDTH'(acc_ff) + SUM_WIDTH'(prod_ff);

   always_comb begin
      acc_in         = acc_ff;
      chunk_count_in = chunk_count_ff;
      rem_in         = rem_ff;
      bit_idx_in     = bit_idx_ff;
      if (ctrl.acc) begin
         acc_in     = sum[ACC_WIDTH-1:0];
         rem_in     = '0;
         bit_idx_in = IDX_WIDTH'(ACC_WIDTH - 1);
         if (!last_ff) begin
            chunk_count_in = status.chunk_hit ? '0 : chunk_next;
         end
      end
      if (ctrl.sub && ge) begin
         acc_in = diff[ACC_WIDTH-1:0];
      end
      if (ctrl.div) begin
         rem_in     = ge ? diff[MOD_WIDTH-1:0] : rem_shift[MOD_WIDTH-1:0];
         bit_idx_in = bit_idx_ff - IDX_WIDTH'(1);
      end
      if (ctrl.fin) begin
         acc_in         = '0;
         chunk_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         chunk_count_ff <= '0;
      end else begin
         acc_ff         <= acc_in;
         chunk_count_ff <= chunk_count_in;
      end
      rem_ff     <= rem_in;
      bit_idx_ff <= bit_idx_in;
   end

   // Output register; with modulus zero the sum passes through masked.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.fin) begin
         residue_ff <= status.mod_zero ? acc_ff[RES_WIDTH-1:0] : rem_ff;
      end
   end

   assign req.ready   = ctrl.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.residue = residue_ff;

   // A taken request blocks the next one until its work is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      status.req_fire |=> !req.ready)
      else $error("request accepted while previous one still in work");

   // The sum must hold still while its remainder is being formed.
   a_acc_stable_in_div: assert property (@(posedge clock) disable iff (reset)
      ctrl.div |=> $stable(acc_ff))
      else $error("accumulator changed during remainder steps");

   // A loaded residue lies below a nonzero modulus.
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.fin |=> ($past(modulus_ff) == '0 || residue_ff < $past(modulus_ff)))
      else $error("residue not reduced below modulus");
endmodule
